@@ design/rhsv_pkg.sv @@
package rhsv_pkg;

    // field widths
    localparam int CHAN_W = 8;
    localparam int PCT_W  = 7;
    localparam int HUE_W  = 9;
    localparam int NUM_W  = 14;
    localparam int DEN_W  = 7;
    localparam int QUO_W  = 7;

    // c*100/255 as a multiply by a reciprocal, exact for every 8-bit c
    localparam int              SCALE_SHIFT = 24;
    localparam logic [22:0]     SCALE_MUL   = 23'd6579400;

    // hue*60/100 = hue*3/5, done as hue*3*13108 >> 16 (exact below 1600)
    localparam int              HUE_SHIFT   = 16;
    localparam logic [15:0]     HUE_MUL     = 16'd39324;
    localparam int              HUE_PROD_W  = HUE_W + 16;

    localparam logic [PCT_W-1:0] PCT_100    = 7'd100;
    localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;

    // sector of the largest channel
    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    // values that ride along the divider without being touched
    typedef struct packed {
        logic               gray;
        logic               neg;
        sector_t            sector;
        logic [PCT_W-1:0]   value;
    } side_t;

    // one request through the divider: hue and saturation quotients side by side
    typedef struct packed {
        logic [NUM_W-1:0]   rem_h;
        logic [DEN_W-1:0]   den_h;
        logic [QUO_W-1:0]   quo_h;
        logic [NUM_W-1:0]   rem_s;
        logic [DEN_W-1:0]   den_s;
        logic [QUO_W-1:0]   quo_s;
        side_t              side;
    } div_req_t;

endpackage

@@ design/rhsv_div_pipe.sv @@
module rhsv_div_pipe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhsv_pkg::div_req_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rhsv_pkg::div_req_t  out_data
);
    import rhsv_pkg::*;

    // one restoring step: compare against the shifted divisor, subtract on success
    function automatic logic [NUM_W:0] div_step(logic [NUM_W-1:0] rem,
                                                logic [DEN_W-1:0] den,
                                                int unsigned sh);
        logic [NUM_W-1:0] trial;
        trial = NUM_W'(den) << sh;
        if (rem >= trial)
        begin
            return {1'b1, rem - trial};
        end
        return {1'b0, rem};
    endfunction

    logic     [QUO_W-1:0] valid_reg;
    div_req_t             stage_reg [QUO_W];
    logic     [QUO_W:0]   ready;

    assign ready[QUO_W] = out_ready;
    assign in_ready     = ready[0];
    assign out_valid    = valid_reg[QUO_W-1];
    assign out_data     = stage_reg[QUO_W-1];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_step
            localparam int unsigned SH = QUO_W - 1 - i;
            div_req_t       src;
            logic           src_valid;
            div_req_t       stage_next;
            logic [NUM_W:0] step_h;
            logic [NUM_W:0] step_s;

            if (i == 0)
            begin : g_first
                assign src       = in_data;
                assign src_valid = in_valid;
            end
            else
            begin : g_rest
                assign src       = stage_reg[i-1];
                assign src_valid = valid_reg[i-1];
            end

            assign ready[i] = !valid_reg[i] || ready[i+1];

            // quotient bit SH for both divisions
            always_comb
            begin
                step_h            = div_step(src.rem_h, src.den_h, SH);
                step_s            = div_step(src.rem_s, src.den_s, SH);
                stage_next        = src;
                stage_next.rem_h  = step_h[NUM_W-1:0];
                stage_next.quo_h[SH] = step_h[NUM_W];
                stage_next.rem_s  = step_s[NUM_W-1:0];
                stage_next.quo_s[SH] = step_s[NUM_W];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (ready[i])
                begin
                    valid_reg[i] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[i] && src_valid)
                begin
                    stage_reg[i] <= stage_next;
                end
            end
        end
    endgenerate

    // a colored pixel always has quotients within 0..100
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.side.gray |->
            out_data.quo_h <= PCT_100 && out_data.quo_s <= PCT_100)
        else $error("divider quotient out of range");

    // the last remainder is below its divisor for a nonzero divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.side.gray |->
            out_data.rem_h < NUM_W'(out_data.den_h) &&
            out_data.rem_s < NUM_W'(out_data.den_s))
        else $error("divider remainder not reduced");

    // an empty divider never stalls its input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && valid_reg == '0 |-> in_ready)
        else $error("divider stalls while empty");

endmodule

@@ design/rgb_to_hsv_converter.sv @@
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: red, green, blue
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: hue, saturation, brightness
//
// one pixel per clock unless m_axis_tready stalls; registers in order: scale, sort,
// 7 divider steps, hue scale multiply, output register; the 7-step divider sets the depth
// each stage advances when it is empty or the stage after it moves,
// so bubbles close up and a stall holds every request in place
// rst_n clears the valid bits only; payload registers are not reset
module rgb_to_hsv_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue [8:0], saturation [15:9], brightness [22:16]
);
    import rhsv_pkg::*;

    // stage 0: channels scaled to percent
    logic               s0_valid_reg;
    logic [PCT_W-1:0]   s0_r_reg;
    logic [PCT_W-1:0]   s0_g_reg;
    logic [PCT_W-1:0]   s0_b_reg;
    logic [PCT_W-1:0]   s0_r_next;
    logic [PCT_W-1:0]   s0_g_next;
    logic [PCT_W-1:0]   s0_b_next;
    logic               s0_ready;

    // stage 1: divider request
    logic               s1_valid_reg;
    div_req_t           s1_req_reg;
    div_req_t           s1_req_next;
    logic               s1_ready;

    // divider input and output
    logic               div_in_ready;
    logic               div_valid;
    logic               div_ready;
    div_req_t           div_data;

    // stage 2: hue scale product
    logic                   s2_valid_reg;
    logic [HUE_PROD_W-1:0]  s2_prod_reg;
    logic                   s2_neg_reg;
    logic                   s2_gray_reg;
    logic [PCT_W-1:0]       s2_sat_reg;
    logic [PCT_W-1:0]       s2_val_reg;
    logic [HUE_PROD_W-1:0]  s2_prod_next;
    logic                   s2_neg_next;
    logic                   s2_ready;

    // stage 3: output register
    logic               out_valid_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [PCT_W-1:0]   sat_reg;
    logic [PCT_W-1:0]   val_reg;
    logic [HUE_W-1:0]   hue_next;
    logic               out_ready;

    // ready chain
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign div_ready     = s2_ready;
    assign s1_ready      = !s1_valid_reg || div_in_ready;
    assign s0_ready      = !s0_valid_reg || s1_ready;
    assign s_axis_tready = s0_ready;

    // channel scaling by a reciprocal of 255
    function automatic logic [PCT_W-1:0] scale_pct(logic [CHAN_W-1:0] c);
        logic [CHAN_W+22:0] prod;
        prod = (CHAN_W+23)'(c) * (CHAN_W+23)'(SCALE_MUL);
        return prod[SCALE_SHIFT +: PCT_W];
    endfunction

    always_comb
    begin
        s0_r_next = scale_pct(s_axis_tdata[7:0]);
        s0_g_next = scale_pct(s_axis_tdata[15:8]);
        s0_b_next = scale_pct(s_axis_tdata[23:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && s_axis_tvalid)
        begin
            s0_r_reg <= s0_r_next;
            s0_g_reg <= s0_g_next;
            s0_b_reg <= s0_b_next;
        end
    end

    // max, min, sector and division operands
    always_comb
    begin
        logic [PCT_W-1:0] hi;
        logic [PCT_W-1:0] lo;
        logic [PCT_W-1:0] delta;
        logic [PCT_W:0]   diff;
        logic [PCT_W-1:0] mag;
        sector_t          sector;

        hi = s0_r_reg;
        lo = s0_r_reg;
        if (s0_g_reg < lo) lo = s0_g_reg;
        if (s0_b_reg < lo) lo = s0_b_reg;
        if (s0_g_reg > hi) hi = s0_g_reg;
        if (s0_b_reg > hi) hi = s0_b_reg;
        delta = hi - lo;

        // red wins ties over green, green over blue
        if (s0_r_reg == hi)
        begin
            sector = SECTOR_RED;
            diff   = {1'b0, s0_g_reg} - {1'b0, s0_b_reg};
        end
        else if (s0_g_reg == hi)
        begin
            sector = SECTOR_GREEN;
            diff   = {1'b0, s0_b_reg} - {1'b0, s0_r_reg};
        end
        else
        begin
            sector = SECTOR_BLUE;
            diff   = {1'b0, s0_r_reg} - {1'b0, s0_g_reg};
        end
        mag = diff[PCT_W] ? PCT_W'(-diff) : diff[PCT_W-1:0];

        s1_req_next.rem_h       = NUM_W'(mag) * NUM_W'(PCT_100);
        s1_req_next.den_h       = delta;
        s1_req_next.quo_h       = '0;
        s1_req_next.rem_s       = NUM_W'(delta) * NUM_W'(PCT_100);
        s1_req_next.den_s       = hi;
        s1_req_next.quo_s       = '0;
        s1_req_next.side.gray   = (hi == lo);
        s1_req_next.side.neg    = diff[PCT_W];
        s1_req_next.side.sector = sector;
        s1_req_next.side.value  = hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_req_reg <= s1_req_next;
        end
    end

    // both divisions, one quotient bit per stage
    rhsv_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (div_in_ready),
        .in_data   (s1_req_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // signed hue from sector offset and quotient, magnitude times 3/5 scale
    always_comb
    begin
        logic signed [HUE_W:0] hue_s;
        logic signed [HUE_W:0] quo_s;
        logic [HUE_W-1:0]      hue_mag;

        quo_s = (HUE_W+1)'(signed'({1'b0, div_data.quo_h}));
        if (div_data.side.neg)
        begin
            quo_s = -quo_s;
        end
        case (div_data.side.sector)
            SECTOR_GREEN: hue_s = quo_s + (HUE_W+1)'(200);
            SECTOR_BLUE:  hue_s = quo_s + (HUE_W+1)'(400);
            default:      hue_s = quo_s;
        endcase
        s2_neg_next  = hue_s[HUE_W];
        hue_mag      = s2_neg_next ? HUE_W'(-hue_s) : hue_s[HUE_W-1:0];
        s2_prod_next = HUE_PROD_W'(hue_mag) * HUE_PROD_W'(HUE_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && div_valid)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_neg_reg  <= s2_neg_next;
            s2_gray_reg <= div_data.side.gray;
            s2_sat_reg  <= div_data.quo_s;
            s2_val_reg  <= div_data.side.value;
        end
    end

    // truncate toward zero, wrap negative hue by 360, and force zero hue for a gray pixel
    always_comb
    begin
        logic [HUE_W-1:0] q;
        q = s2_prod_reg[HUE_SHIFT +: HUE_W];
        if (s2_gray_reg)
        begin
            hue_next = '0;
        end
        else if (s2_neg_reg && q != '0)
        begin
            hue_next = HUE_WRAP - q;
        end
        else
        begin
            hue_next = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            hue_reg <= hue_next;
            sat_reg <= s2_gray_reg ? '0 : s2_sat_reg;
            val_reg <= s2_val_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, val_reg, sat_reg, hue_reg};

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> hue_reg < HUE_WRAP)
        else $error("hue out of range");

    // percent outputs stay within 0..100
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> sat_reg <= PCT_100 && val_reg <= PCT_100)
        else $error("percent output out of range");

    // zero saturation only comes from a gray pixel, which has zero hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && sat_reg == '0 |-> hue_reg == '0)
        else $error("gray pixel with nonzero hue");

    // an empty output register never holds off the input
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule
